[rtl/core/vrac_pkg.sv]
package vrac_pkg;

  localparam int COORD_WIDTH    = 24;
  localparam int COEF_WIDTH     = 16;
  localparam int COEF_FRAC_BITS = 14;

  // intermediate widths of one rotation
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PROD_W = DIFF_W + COEF_WIDTH;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RND_W  = SUM_W - COEF_FRAC_BITS;
  localparam int CTR_W  = RND_W + 1;

  localparam int CFG_IDX_W = 3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [COEF_WIDTH-1:0]  coef_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic signed [RND_W-1:0]       rnd_t;
  typedef logic signed [CTR_W-1:0]       ctr_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COS_Z = 3'd0,
    REG_SIN_Z = 3'd1,
    REG_COS_Y = 3'd2,
    REG_SIN_Y = 3'd3,
    REG_COS_X = 3'd4,
    REG_SIN_X = 3'd5
  } cfg_reg_e;

  localparam coef_t COEF_ONE = coef_t'(1 << COEF_FRAC_BITS);

  // one vertex in flight with its pivot and running clip flag
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    coord_t px;
    coord_t py;
    coord_t pz;
    logic   sat;
  } vert_t;

endpackage

[rtl/core/vrac_rot_stage.sv]
module vrac_rot_stage import vrac_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  vert_t  in_vert,
  input  coord_t a,
  input  coord_t b,
  input  coord_t ca,
  input  coord_t cb,
  input  coef_t  c,
  input  coef_t  s,
  output logic   out_valid,
  output vert_t  out_vert,
  output coord_t out_a,
  output coord_t out_b,
  output logic   out_sat
);

  localparam sum_t ROUND_HALF = sum_t'(1) <<< (COEF_FRAC_BITS - 1);
  localparam ctr_t CLIP_HI = ctr_t'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam ctr_t CLIP_LO = ctr_t'(-(64'sd1 <<< (COORD_WIDTH - 1)));

  logic [3:0] vld;
  vert_t vert1, vert2, vert3;
  coord_t ca1, cb1, ca2, cb2, ca3, cb3;
  diff_t ta, tb;
  prod_t p_ac, p_bs, p_as, p_bc;
  rnd_t ra, rb;
  sum_t sum_a, sum_b;
  ctr_t na, nb;
  logic clip_a, clip_b;

  // round to nearest, ties up: add half then floor shift
  always_comb begin
    sum_a = sum_t'(p_ac) - sum_t'(p_bs) + ROUND_HALF;
    sum_b = sum_t'(p_as) + sum_t'(p_bc) + ROUND_HALF;
    na = ctr_t'(ra) + ctr_t'(ca3);
    nb = ctr_t'(rb) + ctr_t'(cb3);
    clip_a = (na > CLIP_HI) || (na < CLIP_LO);
    clip_b = (nb > CLIP_HI) || (nb < CLIP_LO);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // difference from centre
      ta    <= diff_t'(a) - diff_t'(ca);
      tb    <= diff_t'(b) - diff_t'(cb);
      vert1 <= in_vert;
      ca1   <= ca;
      cb1   <= cb;
      // products
      p_ac  <= prod_t'(ta) * prod_t'(c);
      p_bs  <= prod_t'(tb) * prod_t'(s);
      p_as  <= prod_t'(ta) * prod_t'(s);
      p_bc  <= prod_t'(tb) * prod_t'(c);
      vert2 <= vert1;
      ca2   <= ca1;
      cb2   <= cb1;
      // sum and round
      ra    <= rnd_t'(sum_a >>> COEF_FRAC_BITS);
      rb    <= rnd_t'(sum_b >>> COEF_FRAC_BITS);
      vert3 <= vert2;
      ca3   <= ca2;
      cb3   <= cb2;
      // centre back and clamp
      out_a <= (na > CLIP_HI) ? coord_t'(CLIP_HI) :
               (na < CLIP_LO) ? coord_t'(CLIP_LO) : coord_t'(na);
      out_b <= (nb > CLIP_HI) ? coord_t'(CLIP_HI) :
               (nb < CLIP_LO) ? coord_t'(CLIP_LO) : coord_t'(nb);
      out_sat  <= vert3.sat | clip_a | clip_b;
      out_vert <= vert3;
    end
  end

  assign out_valid = vld[3];

endmodule

[rtl/core/vertex_rotate_about_center_top.sv]
// rotates a vertex about a pivot point: about z, then y, then x
//
// s_* channel: one beat is one vertex and its pivot, six signed q15.8 words
// m_* channel: one beat is the rotated vertex; m_tuser flags that some axis
//   stage clipped a coordinate to the q15.8 range
// cfg_* channel: writes the sine/cosine pair of each axis in q2.14, always
//   ready; write only while no vertex is in flight
//
// latency is 12 cycles from the input beat to m_tvalid: each axis takes four
//   register steps (centre subtract, products, round, centre add and clamp)
// throughput is one vertex per cycle; the multipliers of each axis sit in
//   their own register step and are not shared
// when the receiver stalls a full output register, the whole pipeline holds
//   and s_tready drops in the same cycle; nothing is dropped or repeated
// reset empties the pipeline and sets every axis to the identity (cos 1,
//   sin 0)
module vertex_rotate_about_center_top import vrac_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // in_x, in_y, in_z, pivot_x, pivot_y, pivot_z, 24 bits each from bit 0
  input  logic [143:0]         s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // out_x, out_y, out_z, 24 bits each from bit 0
  output logic [71:0]          m_tdata,
  // saturated
  output logic                 m_tuser,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  coef_t cos_z, sin_z, cos_y, sin_y, cos_x, sin_x;

  logic  adv;
  vert_t in_vert, vz_vert, vy_vert, vx_vert;
  vert_t after_z, after_y;
  logic  vz_valid, vy_valid, vx_valid;
  coord_t z_a, z_b, y_a, y_b, x_a, x_b;
  logic  z_sat, y_sat, x_sat;

  // whole pipeline moves unless the output beat is stuck
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_z <= COEF_ONE;
      sin_z <= '0;
      cos_y <= COEF_ONE;
      sin_y <= '0;
      cos_x <= COEF_ONE;
      sin_x <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_COS_Z: cos_z <= coef_t'(cfg_data);
        REG_SIN_Z: sin_z <= coef_t'(cfg_data);
        REG_COS_Y: cos_y <= coef_t'(cfg_data);
        REG_SIN_Y: sin_y <= coef_t'(cfg_data);
        REG_COS_X: cos_x <= coef_t'(cfg_data);
        REG_SIN_X: sin_x <= coef_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // unpack input beat
  always_comb begin
    in_vert.x   = coord_t'(s_tdata[23:0]);
    in_vert.y   = coord_t'(s_tdata[47:24]);
    in_vert.z   = coord_t'(s_tdata[71:48]);
    in_vert.px  = coord_t'(s_tdata[95:72]);
    in_vert.py  = coord_t'(s_tdata[119:96]);
    in_vert.pz  = coord_t'(s_tdata[143:120]);
    in_vert.sat = 1'b0;
  end

  // about z: (x, y)
  vrac_rot_stage u_rot_z (
    .clk(clk), .rst(rst), .en(adv), .in_valid(s_tvalid),
    .in_vert(in_vert), .a(in_vert.x), .b(in_vert.y),
    .ca(in_vert.px), .cb(in_vert.py), .c(cos_z), .s(sin_z),
    .out_valid(vz_valid), .out_vert(vz_vert),
    .out_a(z_a), .out_b(z_b), .out_sat(z_sat)
  );

  always_comb begin
    after_z     = vz_vert;
    after_z.x   = z_a;
    after_z.y   = z_b;
    after_z.sat = z_sat;
  end

  // about y: (z, x)
  vrac_rot_stage u_rot_y (
    .clk(clk), .rst(rst), .en(adv), .in_valid(vz_valid),
    .in_vert(after_z), .a(after_z.z), .b(after_z.x),
    .ca(after_z.pz), .cb(after_z.px), .c(cos_y), .s(sin_y),
    .out_valid(vy_valid), .out_vert(vy_vert),
    .out_a(y_a), .out_b(y_b), .out_sat(y_sat)
  );

  always_comb begin
    after_y     = vy_vert;
    after_y.z   = y_a;
    after_y.x   = y_b;
    after_y.sat = y_sat;
  end

  // about x: (y, z); its last register is the output register
  vrac_rot_stage u_rot_x (
    .clk(clk), .rst(rst), .en(adv), .in_valid(vy_valid),
    .in_vert(after_y), .a(after_y.y), .b(after_y.z),
    .ca(after_y.py), .cb(after_y.pz), .c(cos_x), .s(sin_x),
    .out_valid(vx_valid), .out_vert(vx_vert),
    .out_a(x_a), .out_b(x_b), .out_sat(x_sat)
  );

  assign m_tvalid = vx_valid;
  assign m_tdata  = {x_b, x_a, vx_vert.x};
  assign m_tuser  = x_sat;

  // reset leaves nothing in flight
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && !vz_valid && !vy_valid)
    else $error("pipeline not empty after reset");

  // a stall freezes every axis stage, so no vertex is lost or doubled
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable({vz_valid, vy_valid, vx_valid}) && $stable(m_tdata))
    else $error("pipeline moved during a stall");

endmodule
